// ===== src/cars_pkg.sv =====
// cave automaton row step: shared constants, register codes and types
// used by the interfaces and every module of the block, no dependencies
package cars_pkg;

    // widest grid that the line buffers and the cell lanes cover
    localparam int MAX_COLUMNS = 64;
    // fixed field widths of the row word and the registers
    localparam int ROW_BITS = 64;
    localparam int WIDTH_BITS = 7;
    localparam int THRESH_BITS = 4;
    localparam int CNT_BITS = 4;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 7;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_BITS-1:0] REG_ROW_WIDTH = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BIRTH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_DEATH_THRESHOLD = 2'd2;

    // register values after reset
    localparam logic [WIDTH_BITS-1:0] ROW_WIDTH_RESET = 7'd64;
    localparam logic [THRESH_BITS-1:0] BIRTH_THRESHOLD_RESET = 4'd4;
    localparam logic [THRESH_BITS-1:0] DEATH_THRESHOLD_RESET = 4'd3;

    typedef struct packed {
        logic [WIDTH_BITS-1:0]  row_width;
        logic [THRESH_BITS-1:0] birth_threshold;
        logic [THRESH_BITS-1:0] death_threshold;
    } cfg_t;

    // one result row to compute: the row itself and its two neighbors
    typedef struct packed {
        logic [ROW_BITS-1:0] up_row;
        logic [ROW_BITS-1:0] mid_row;
        logic [ROW_BITS-1:0] down_row;
        logic                up_ok;
        logic                down_ok;
        logic                last;
    } job_t;

endpackage

// ===== src/cars_ifs.sv =====
// cave automaton row step: valid/ready channel interfaces for input rows,
// result rows and register writes; depends on cars_pkg
interface cars_row_in_if;
    logic                          valid;
    logic                          ready;
    logic [cars_pkg::ROW_BITS-1:0] row_cells;
    logic                          last_row;

    modport source (output valid, output row_cells, output last_row, input ready);
    modport sink (input valid, input row_cells, input last_row, output ready);
endinterface

interface cars_row_out_if;
    logic                          valid;
    logic                          ready;
    logic [cars_pkg::ROW_BITS-1:0] next_cells;
    logic                          row_changed;
    logic                          frame_changed;
    logic                          last_of_frame;

    modport source (output valid, output next_cells, output row_changed,
                    output frame_changed, output last_of_frame, input ready);
    modport sink (input valid, input next_cells, input row_changed,
                  input frame_changed, input last_of_frame, output ready);
endinterface

interface cars_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [cars_pkg::CFG_IDX_BITS-1:0]  index;
    logic [cars_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/cave_automaton_row_step.sv =====
// cave automaton row step: top level with job queue, cell logic and result
// register; depends on cars_pkg, cars_ifs, cars_cfg_regs, cars_job_queue, cars_row_eval
//
// One generation of a cave-style cellular automaton, streamed one grid row per
// input word, top row first, the bottom row marked by last_row. Each cell counts
// its 8 neighbors (anything outside the grid or past row_width counts as alive);
// a live cell dies below death_threshold, a dead cell is born above
// birth_threshold, others keep their state. Result rows lag the input by one
// row: the first row of a frame gives no result, each later row gives the result
// for the row before it, and the bottom row gives two (a one-row grid gives one).
// All 64 columns are computed side by side in combinational logic between the
// job register and the result register, so the block takes one input word per
// clock while results drain; a bottom row fills both job queue slots and stalls
// the feed, since both of its results go through the one cell-logic unit.
// Results are held in an output register, and the next word is taken while a
// result waits, as long as the job queue is empty. frame_changed accumulates
// row_changed over a frame and is final on the word with last_of_frame.
// Register writes are always taken and belong in idle time between frames.
module cave_automaton_row_step (
    input  logic            clk,
    input  logic            rst_n,
    cars_row_in_if.sink     feed,
    cars_row_out_if.source  result,
    cars_cfg_if.sink        cfg
);

    cars_pkg::cfg_t cfg_val;
    cars_pkg::job_t head_job;
    logic           head_valid;
    logic           issue;
    logic           out_free;

    logic [cars_pkg::ROW_BITS-1:0] eval_cells;
    logic                          eval_changed;

    // result register
    logic                          out_valid_reg;
    logic [cars_pkg::ROW_BITS-1:0] next_cells_reg;
    logic                          row_changed_reg;
    logic                          frame_changed_reg;
    logic                          last_of_frame_reg;
    // change seen in earlier rows of the current frame
    logic                          frame_acc_reg, frame_acc_next;

    // register writes never stall
    assign cfg.ready = 1'b1;

    cars_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg_out  (cfg_val)
    );

    // line buffers turn each input row into zero, one or two jobs
    cars_job_queue u_job_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .feed_valid (feed.valid),
        .row_cells  (feed.row_cells),
        .last_row   (feed.last_row),
        .feed_ready (feed.ready),
        .issue      (issue),
        .head_job   (head_job),
        .head_valid (head_valid)
    );

    cars_row_eval u_row_eval (
        .job     (head_job),
        .cfg     (cfg_val),
        .cells   (eval_cells),
        .changed (eval_changed)
    );

    // the head job moves into the result register whenever it is free or drained
    assign out_free = !out_valid_reg || result.ready;
    assign issue    = head_valid && out_free;

    // frame flag starts over after the bottom row's result
    assign frame_acc_next = head_job.last ? 1'b0 : (frame_acc_reg | eval_changed);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            frame_acc_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= head_valid;
            if (issue)
                frame_acc_reg <= frame_acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            next_cells_reg    <= eval_cells;
            row_changed_reg   <= eval_changed;
            frame_changed_reg <= frame_acc_reg | eval_changed;
            last_of_frame_reg <= head_job.last;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.next_cells    = next_cells_reg;
    assign result.row_changed   = row_changed_reg;
    assign result.frame_changed = frame_changed_reg;
    assign result.last_of_frame = last_of_frame_reg;

`ifndef SYNTHESIS
    a_row_change_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!row_changed_reg || frame_changed_reg))
        else $error("row change missing from the frame flag");
    a_frame_flag_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        issue && head_job.last |=> !frame_acc_reg)
        else $error("frame flag not cleared after the bottom row");
`endif

endmodule

// ===== src/cars_cfg_regs.sv =====
// cave automaton row step: row width and threshold registers
// depends on cars_pkg
module cars_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [cars_pkg::CFG_IDX_BITS-1:0]  wr_index,
    input  logic [cars_pkg::CFG_DATA_BITS-1:0] wr_data,
    output cars_pkg::cfg_t                     cfg_out
);

    cars_pkg::cfg_t cfg_reg;
    cars_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                cars_pkg::REG_ROW_WIDTH:
                    cfg_next.row_width = wr_data;
                cars_pkg::REG_BIRTH_THRESHOLD:
                    cfg_next.birth_threshold = wr_data[cars_pkg::THRESH_BITS-1:0];
                cars_pkg::REG_DEATH_THRESHOLD:
                    cfg_next.death_threshold = wr_data[cars_pkg::THRESH_BITS-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.row_width       <= cars_pkg::ROW_WIDTH_RESET;
            cfg_reg.birth_threshold <= cars_pkg::BIRTH_THRESHOLD_RESET;
            cfg_reg.death_threshold <= cars_pkg::DEATH_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

// ===== src/cars_job_queue.sv =====
// cave automaton row step: the two line buffers and a two-entry queue of
// row jobs that sits in front of the cell logic; depends on cars_pkg
module cars_job_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          feed_valid,
    input  logic [cars_pkg::ROW_BITS-1:0] row_cells,
    input  logic                          last_row,
    output logic                          feed_ready,
    input  logic                          issue,
    output cars_pkg::job_t                head_job,
    output logic                          head_valid
);

    logic [1:0]                    rows_held_reg, rows_held_next;
    logic [cars_pkg::ROW_BITS-1:0] above_reg, middle_reg;
    cars_pkg::job_t                job0_reg, job0_next;
    cars_pkg::job_t                job1_reg, job1_next;
    logic                          v0_reg, v0_next;
    logic                          v1_reg, v1_next;

    logic           accept;
    logic           first_row;
    logic           has_a, has_b;
    cars_pkg::job_t new_a, new_b;

    // an item may bring two jobs, so take one only with both slots free after issue
    assign feed_ready = !v1_reg && (!v0_reg || issue);
    assign accept     = feed_valid && feed_ready;
    assign first_row  = (rows_held_reg == 2'd0);

    // first job: the held middle row, or a single-row grid on its own
    assign has_a = !(first_row && !last_row);
    // second job: the bottom row flushed after its upper neighbor
    assign has_b = !first_row && last_row;

    always_comb
    begin
        if (first_row)
        begin
            new_a.up_row   = '0;
            new_a.up_ok    = 1'b0;
            new_a.mid_row  = row_cells;
            new_a.down_row = '0;
            new_a.down_ok  = 1'b0;
            new_a.last     = 1'b1;
        end
        else
        begin
            new_a.up_row   = above_reg;
            new_a.up_ok    = (rows_held_reg == 2'd2);
            new_a.mid_row  = middle_reg;
            new_a.down_row = row_cells;
            new_a.down_ok  = 1'b1;
            new_a.last     = 1'b0;
        end
        new_b.up_row   = middle_reg;
        new_b.up_ok    = 1'b1;
        new_b.mid_row  = row_cells;
        new_b.down_row = '0;
        new_b.down_ok  = 1'b0;
        new_b.last     = 1'b1;
    end

    always_comb
    begin
        job0_next = job0_reg;
        job1_next = job1_reg;
        v0_next   = v0_reg;
        v1_next   = v1_reg;
        if (issue)
        begin
            job0_next = job1_reg;
            v0_next   = v1_reg;
            v1_next   = 1'b0;
        end
        if (accept && has_a)
        begin
            if (!v0_next)
            begin
                job0_next = new_a;
                v0_next   = 1'b1;
                if (has_b)
                begin
                    job1_next = new_b;
                    v1_next   = 1'b1;
                end
            end
            else
            begin
                job1_next = new_a;
                v1_next   = 1'b1;
            end
        end
    end

    always_comb
    begin
        rows_held_next = rows_held_reg;
        if (accept)
        begin
            if (last_row)
                rows_held_next = 2'd0;
            else if (first_row)
                rows_held_next = 2'd1;
            else
                rows_held_next = 2'd2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_held_reg <= 2'd0;
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
        end
        else
        begin
            rows_held_reg <= rows_held_next;
            v0_reg        <= v0_next;
            v1_reg        <= v1_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job0_reg <= job0_next;
        job1_reg <= job1_next;
        if (accept && !last_row)
        begin
            above_reg  <= middle_reg;
            middle_reg <= row_cells;
        end
    end

    assign head_job   = job0_reg;
    assign head_valid = v0_reg;

`ifndef SYNTHESIS
    a_second_slot_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> v0_reg)
        else $error("second job slot filled with the first slot empty");
    a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        rows_held_reg != 2'd3)
        else $error("held row count out of range");
    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_row |=> rows_held_reg == 2'd0)
        else $error("held rows not cleared after the bottom row");
`endif

endmodule

// ===== src/cars_row_eval.sv =====
// cave automaton row step: one lane per column that counts live neighbors
// and applies the birth and death limits; depends on cars_pkg
module cars_row_eval (
    input  cars_pkg::job_t                job,
    input  cars_pkg::cfg_t                cfg,
    output logic [cars_pkg::ROW_BITS-1:0] cells,
    output logic                          changed
);

    localparam int RB = cars_pkg::ROW_BITS;

    logic [cars_pkg::WIDTH_BITS-1:0] eff_width;
    logic [RB-1:0] col_ok;
    logic [RB-1:0] up_x, mid_x, down_x;
    logic [RB+1:0] up_e, mid_e, down_e;
    logic [RB-1:0] change_bits;

    assign eff_width = (cfg.row_width > cars_pkg::WIDTH_BITS'(cars_pkg::MAX_COLUMNS))
                     ? cars_pkg::WIDTH_BITS'(cars_pkg::MAX_COLUMNS) : cfg.row_width;

    // columns past the width read as walls, missing rows are all wall
    assign up_x   = job.up_ok ? ((job.up_row & col_ok) | ~col_ok) : '1;
    assign mid_x  = (job.mid_row & col_ok) | ~col_ok;
    assign down_x = job.down_ok ? ((job.down_row & col_ok) | ~col_ok) : '1;

    // wall columns on both sides of the grid
    assign up_e   = {1'b1, up_x, 1'b1};
    assign mid_e  = {1'b1, mid_x, 1'b1};
    assign down_e = {1'b1, down_x, 1'b1};

    for (genvar k = 0; k < RB; k++)
    begin : g_col
        logic [cars_pkg::CNT_BITS-1:0] cnt;
        logic                          self_bit;
        logic                          nxt;

        assign col_ok[k] = (cars_pkg::WIDTH_BITS'(k) < eff_width);
        assign self_bit  = mid_e[k+1];
        assign cnt = cars_pkg::CNT_BITS'(up_e[k]) + cars_pkg::CNT_BITS'(up_e[k+1])
                   + cars_pkg::CNT_BITS'(up_e[k+2]) + cars_pkg::CNT_BITS'(mid_e[k])
                   + cars_pkg::CNT_BITS'(mid_e[k+2]) + cars_pkg::CNT_BITS'(down_e[k])
                   + cars_pkg::CNT_BITS'(down_e[k+1]) + cars_pkg::CNT_BITS'(down_e[k+2]);
        assign nxt = self_bit ? !(cnt < cfg.death_threshold)
                              : (cnt > cfg.birth_threshold);
        assign cells[k]       = col_ok[k] & nxt;
        assign change_bits[k] = col_ok[k] & (nxt ^ self_bit);
    end

    assign changed = |change_bits;

endmodule
